// ----- sv/pfba_pkg.sv -----
// Package for the page frame bitmap allocator: sizes, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package pfba_pkg;

  localparam int FRAME_COUNT = 256;
  localparam int MAP_BYTES   = 32;
  localparam int BYTE_W      = 8;
  localparam int BIT_W       = $clog2(BYTE_W);
  localparam int FRAME_W     = 8;
  localparam int ADDR_W      = $clog2(MAP_BYTES);
  localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_WAIT
  } state_e;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] allocated_frame;
    logic [CNT_W-1:0]   free_frames;
    logic               can_allocate;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/pfba_if.sv -----
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none
interface pfba_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfba_pkg::CMD_W-1:0]  command;
  logic [pfba_pkg::FRAME_W-1:0] frame_number;

  modport source (output valid, output command, output frame_number, input ready);
  modport sink   (input valid, input command, input frame_number, output ready);
endinterface

interface pfba_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfba_pkg::STATUS_W-1:0]  status;
  logic [pfba_pkg::FRAME_W-1:0]   allocated_frame;
  logic [pfba_pkg::CNT_W-1:0]     free_frames;
  logic                           can_allocate;

  modport source (output valid, output status, output allocated_frame,
                  output free_frames, output can_allocate, input ready);
  modport sink   (input valid, input status, input allocated_frame,
                  input free_frames, input can_allocate, output ready);
endinterface
`default_nettype wire

// ----- sv/page_frame_bitmap_allocator.sv -----
// Init and query go to the wait state; allocate and free first pass S_RMW, the
// read-modify-write (not an allocate on a full map). Wait loads the result into
// the output register once it is free; a new command is taken only when idle.
// A per-byte full flag picks the first byte with a free frame without scanning.
// Reset (async, active low) and init clear per-byte valid flags at once, so the
// map reads as all free; no clearing pass. Free count resets to the frame total.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_bitmap_allocator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pfba_in_if.sink     in_i,
  pfba_out_if.source  out_o
);

  pfba_pkg::state_e                 state_q, state_d;
  pfba_pkg::cmd_e                   cmd_q, cmd_d;
  logic [pfba_pkg::FRAME_W-1:0]     fnum_q, fnum_d;
  logic [pfba_pkg::ADDR_W-1:0]      addr_q, addr_d;
  pfba_pkg::res_t                   pend_q, pend_d;
  pfba_pkg::res_t                   out_res_q, out_res_d;
  logic                             out_valid_q, out_valid_d;
  logic [pfba_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [pfba_pkg::MAP_BYTES-1:0]   valid_q, valid_d;
  logic [pfba_pkg::MAP_BYTES-1:0]   full_q, full_d;

  logic                             ram_we;
  logic [pfba_pkg::ADDR_W-1:0]      ram_raddr;
  logic [pfba_pkg::BYTE_W-1:0]      ram_wdata;
  logic [pfba_pkg::BYTE_W-1:0]      ram_rdata;

  logic                             accept;
  logic                             out_free;
  logic [pfba_pkg::ADDR_W-1:0]      first_byte;
  logic [pfba_pkg::BYTE_W-1:0]      cur_byte;
  logic [pfba_pkg::BIT_W-1:0]       first_bit;
  logic [pfba_pkg::BIT_W-1:0]       bit_idx;
  logic [pfba_pkg::BYTE_W-1:0]      bit_mask;
  localparam logic [pfba_pkg::CNT_W-1:0] CntMax = pfba_pkg::CNT_W'(pfba_pkg::FRAME_COUNT);

  pfba_ram #(
    .WIDTH (pfba_pkg::BYTE_W),
    .DEPTH (pfba_pkg::MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready   = (state_q == pfba_pkg::S_IDLE);
  assign accept       = in_i.valid && in_i.ready;
  assign out_free     = !out_valid_q || out_o.ready;

  // lowest byte that still holds a free frame
  always_comb begin
    first_byte = '0;
    for (int i = pfba_pkg::MAP_BYTES - 1; i >= 0; i--) begin
      if (!full_q[i]) first_byte = pfba_pkg::ADDR_W'(i);
    end
  end

  // bytes never written since init read as all free
  assign cur_byte = valid_q[addr_q] ? ram_rdata : '0;

  // frame 0 of a byte is its msb
  always_comb begin
    first_bit = '0;
    for (int j = 0; j < pfba_pkg::BYTE_W; j++) begin
      if (!cur_byte[j]) first_bit = pfba_pkg::BIT_W'(pfba_pkg::BYTE_W - 1 - j);
    end
  end

  assign bit_idx  = (cmd_q == pfba_pkg::CMD_ALLOC) ? first_bit
                                                   : fnum_q[pfba_pkg::BIT_W-1:0];
  assign bit_mask = pfba_pkg::BYTE_W'(1) << (pfba_pkg::BYTE_W - 1 - int'(bit_idx));

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    fnum_d    = fnum_q;
    addr_d    = addr_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    full_d    = full_q;
    ram_we    = 1'b0;
    ram_wdata = cur_byte;
    ram_raddr = addr_q;

    unique case (state_q)
      pfba_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d  = pfba_pkg::cmd_e'(in_i.command);
          fnum_d = in_i.frame_number;
          pend_d = '{status: pfba_pkg::ST_OK, allocated_frame: '0,
                     free_frames: cnt_q, can_allocate: (cnt_q != '0)};
          unique case (pfba_pkg::cmd_e'(in_i.command))
            pfba_pkg::CMD_INIT: begin
              valid_d = '0;
              full_d  = '0;
              cnt_d   = CntMax;
              pend_d.free_frames  = CntMax;
              pend_d.can_allocate = 1'b1;
              state_d = pfba_pkg::S_WAIT;
            end
            pfba_pkg::CMD_ALLOC: begin
              if (&full_q) begin
                pend_d.status = pfba_pkg::ST_OOM;
                state_d = pfba_pkg::S_WAIT;
              end else begin
                ram_raddr = first_byte;
                addr_d    = first_byte;
                state_d   = pfba_pkg::S_RMW;
              end
            end
            pfba_pkg::CMD_FREE: begin
              ram_raddr = in_i.frame_number[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
              addr_d    = in_i.frame_number[pfba_pkg::FRAME_W-1:pfba_pkg::BIT_W];
              state_d   = pfba_pkg::S_RMW;
            end
            default: begin
              state_d = pfba_pkg::S_WAIT;
            end
          endcase
        end
      end

      pfba_pkg::S_RMW: begin
        state_d = pfba_pkg::S_WAIT;
        if (cmd_q == pfba_pkg::CMD_ALLOC) begin
          ram_we    = 1'b1;
          ram_wdata = cur_byte | bit_mask;
          valid_d[addr_q] = 1'b1;
          full_d[addr_q]  = &(cur_byte | bit_mask);
          cnt_d = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
          pend_d = '{status: pfba_pkg::ST_OK, allocated_frame: {addr_q, first_bit},
                     free_frames: cnt_d, can_allocate: (cnt_d != '0)};
        end else if ((cur_byte & bit_mask) != '0) begin
          ram_we    = 1'b1;
          ram_wdata = cur_byte & ~bit_mask;
          valid_d[addr_q] = 1'b1;
          full_d[addr_q]  = 1'b0;
          cnt_d = (cnt_q != CntMax) ? cnt_q + 1'b1 : cnt_q;
          pend_d = '{status: pfba_pkg::ST_OK, allocated_frame: '0,
                     free_frames: cnt_d, can_allocate: (cnt_d != '0)};
        end else begin
          pend_d = '{status: pfba_pkg::ST_NOT_USED, allocated_frame: '0,
                     free_frames: cnt_q, can_allocate: (cnt_q != '0)};
        end
      end

      pfba_pkg::S_WAIT: begin
        if (out_free) state_d = pfba_pkg::S_IDLE;
      end

      default: begin
        state_d = pfba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    if (state_q == pfba_pkg::S_WAIT && out_free) begin
      out_valid_d = 1'b1;
      out_res_d   = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfba_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= CntMax;
      valid_q     <= '0;
      full_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    fnum_q    <= fnum_d;
    addr_q    <= addr_d;
    pend_q    <= pend_d;
    out_res_q <= out_res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_res_q.status;
  assign out_o.allocated_frame = out_res_q.allocated_frame;
  assign out_o.free_frames     = out_res_q.free_frames;
  assign out_o.can_allocate    = out_res_q.can_allocate;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("free count above frame total");

  a_alloc_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfba_pkg::S_RMW && cmd_q == pfba_pkg::CMD_ALLOC) |-> !(&full_q))
    else $error("allocate read-modify-write with a full map");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(addr_q)])
    else $error("map byte written but not marked valid");

  a_pending_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfba_pkg::S_WAIT && out_free) |=> (out_valid_q && out_res_q == $past(pend_q)))
    else $error("pending result not moved to output");
`endif

endmodule
`default_nettype wire

// ----- sv/pfba_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
